// ----- hdl/bfc_pkg.sv -----
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared widths, types and constants for the box frustum cull test.
// ----------------------------------------------------------------------------
package bfc_pkg;

	localparam int COORD_W    = 16;
	localparam int COEF_W     = 16;
	localparam int FRAC_BITS  = 8;
	localparam int PROD_W     = COORD_W + COEF_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int CMP_W      = SUM_W + 1;
	localparam int CORNERS    = 8;
	localparam int IN_FIELD_W = 6 * COORD_W + 3;
	localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_COL_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_Y = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COL_Z = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COL_W = 8'd3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [CMP_W-1:0]   cmp_t;

	localparam cmp_t ONE_Q20 = cmp_t'(1) <<< 20;

	typedef struct packed {
		logic       valid;
		logic [2:0] cull;
	} ctl_t;

endpackage

// ----- hdl/box_frustum_cull_test_unit.sv -----
// ----------------------------------------------------------------------------
// box_frustum_cull_test_unit
// Axis-aligned box against view frustum cull test, streaming.
// ----------------------------------------------------------------------------
// One box word enters per clock and passes through a product stage, a
// corner sum stage, a plane compare stage and the decision stage that
// drives the output register; the whole pipe holds only while the output
// word waits to be taken. The user must write the matrix columns through
// the cfg port only while the pipe is empty; the block does not enforce it.
module box_frustum_cull_test_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, cull_in, zero pad
	input  logic [bfc_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// is_outside, cull_out, zero pad
	output logic [bfc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bfc_pkg::*;

	logic [63:0] mat_q [4];
	coord_t      lo [3];
	coord_t      hi [3];
	sum_t        clip_s2 [8][4];
	logic        adv;
	ctl_t        ctl_s1, ctl_s2, ctl_s3;
	logic [7:0]  neg_s3 [3];
	logic [7:0]  pos_s3 [3];
	logic [7:0]  in_s3 [3];
	logic        outside_q;
	logic [2:0]  cull_q, cull_src_q;
	logic        outside_c;
	logic [2:0]  cull_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) mat_q[c] <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COL_X: mat_q[0] <= cfg_data;
				REG_COL_Y: mat_q[1] <= cfg_data;
				REG_COL_Z: mat_q[2] <= cfg_data;
				REG_COL_W: mat_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lo[a] = s_tdata[COORD_W*a +: COORD_W];
			hi[a] = s_tdata[COORD_W*(a+3) +: COORD_W];
		end
	end

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	bfc_transform u_xform (
		.clk     (clk),
		.en      (adv),
		.lo      (lo),
		.hi      (hi),
		.mat     (mat_q),
		.clip_s2 (clip_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			ctl_s3   <= '0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			ctl_s1.valid <= s_tvalid;
			ctl_s1.cull  <= s_tdata[6*COORD_W +: 3];
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
			m_tvalid     <= ctl_s3.valid;
		end
	end

	// plane compare, exact against |w|, or against ONE_Q20 when w is zero
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < CORNERS; i++) begin
				for (int j = 0; j < 3; j++) begin
					cmp_t v, w, sv, bnd;
					v   = cmp_t'(clip_s2[i][j]);
					w   = cmp_t'(clip_s2[i][3]);
					sv  = (w < 0) ? -v : v;
					bnd = (w == 0) ? ONE_Q20 : ((w < 0) ? -w : w);
					neg_s3[j][i] <= sv < -bnd;
					pos_s3[j][i] <= sv > bnd;
					in_s3[j][i]  <= !(sv < -bnd) && !(sv > bnd);
				end
			end
		end
	end

	always_comb begin
		outside_c = 1'b0;
		cull_c    = ctl_s3.cull;
		for (int j = 0; j < 3; j++) begin
			if (!outside_c && cull_c[j]) begin
				if ((&pos_s3[j]) || (&neg_s3[j])) outside_c = 1'b1;
				else if (&in_s3[j]) cull_c[j] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			outside_q  <= outside_c;
			cull_q     <= cull_c;
			cull_src_q <= ctl_s3.cull;
		end
	end

	assign m_tdata = {4'b0, cull_q, outside_q};

`ifndef SYNTHESIS
	a_stall_only_on_block: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input held without a blocked output");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> ctl_s1.valid)
		else $error("accepted word lost at stage one");
	a_cull_subset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((cull_q & ~cull_src_q) == 3'b000))
		else $error("cull bit set that was not requested");
	a_flow_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctl_s3.valid) |=> m_tvalid)
		else $error("stage three word not delivered");
`endif

endmodule

// ----- hdl/bfc_transform.sv -----
// ----------------------------------------------------------------------------
// bfc_transform
// Two pipeline stages: per-axis coefficient products, then corner sums.
// ----------------------------------------------------------------------------
module bfc_transform (
	input  logic                  clk,
	input  logic                  en,
	input  bfc_pkg::coord_t       lo [3],
	input  bfc_pkg::coord_t       hi [3],
	input  logic [63:0]           mat [4],
	output bfc_pkg::sum_t         clip_s2 [8][4]
);
	import bfc_pkg::*;

	// prod_s1[col][axis][0 = hi, 1 = lo]
	prod_t prod_s1 [4][3][2];
	coef_t bias_s1 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				for (int a = 0; a < 3; a++) begin
					prod_s1[c][a][0] <= hi[a] * $signed(mat[c][16*a +: 16]);
					prod_s1[c][a][1] <= lo[a] * $signed(mat[c][16*a +: 16]);
				end
				bias_s1[c] <= $signed(mat[c][63:48]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CORNERS; i++) begin
				for (int c = 0; c < 4; c++) begin
					clip_s2[i][c] <= sum_t'(prod_s1[c][0][i[2]])
						+ sum_t'(prod_s1[c][1][i[1]])
						+ sum_t'(prod_s1[c][2][i[0]])
						+ (sum_t'(bias_s1[c]) <<< FRAC_BITS);
				end
			end
		end
	end

endmodule
